[sv/ismu_pkg.sv]
// Package for the Ising Metropolis site update core: widths, codes and types.
`default_nettype none

package ismu_pkg;

    // Fixed field widths of the channels.
    localparam int COORD_W    = 6;
    localparam int RND_W      = 16;
    localparam int NSUM_W     = 4;
    localparam int MAG_W      = 14;
    localparam int BOND_W     = 15;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int THR_C_W    = 32;
    localparam int THR_ALL_W  = 2 * CFG_DATA_W + THR_C_W;

    // Operation codes carried in the opcode field.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TRIAL = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_C = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RED,
        S_RD,
        S_LAST,
        S_EVAL,
        S_OUT
    } t_state;

    // Order in which the site and its neighbours are read from the spin memory.
    typedef enum logic [2:0] {
        TAP_SITE,
        TAP_XP,
        TAP_XM,
        TAP_YP,
        TAP_YM
    } t_tap;

endpackage

`default_nettype wire

[sv/ismu_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none

module ismu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One access per cycle: a write, or a read whose data appears next cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

[sv/ising_metropolis_site_update_core.sv]
// Top level of the Ising Metropolis site update core.
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+--------------------------------------------
//  in      | i_valid / o_ready          | opcode, site_x, site_y, spin_value, random
//  out     | o_valid / i_ready          | flipped, new_spin, neighbour_sum, totals
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An item runs from the accepted beat through a reduction step, which subtracts the grid
// size from a coordinate beyond the grid up to floor(63 / min(GRID_WIDTH, GRID_HEIGHT))
// times, then five reads on the single spin memory port (site and four neighbours) and a
// write-back if the spin changes; o_ready is low from the accept until the result is loaded.
// After reset a clearing pass sets all GRID_WIDTH*GRID_HEIGHT spins (4096 by default) to +1
// with o_ready low; configuration beats are taken throughout.
// A result that is not taken holds the sequencer in its last state; o_cfg_ready is always high.
`default_nettype none

module ising_metropolis_site_update_core #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input item channel.
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic                               i_opcode,
    input  wire logic [ismu_pkg::COORD_W-1:0]       i_site_x,
    input  wire logic [ismu_pkg::COORD_W-1:0]       i_site_y,
    input  wire logic                               i_spin_value,
    input  wire logic [ismu_pkg::RND_W-1:0]         i_random_value,
    // Result channel.
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_flipped,
    output logic                                    o_new_spin,
    output logic signed [ismu_pkg::NSUM_W-1:0]      o_neighbour_sum,
    output logic signed [ismu_pkg::MAG_W-1:0]       o_magnetisation,
    output logic signed [ismu_pkg::BOND_W-1:0]      o_bond_total,
    // Configuration write channel.
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [ismu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ismu_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import ismu_pkg::*;

    localparam int SITE_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW         = $clog2(SITE_COUNT);
    localparam int XW         = $clog2(GRID_WIDTH);
    localparam int YW         = $clog2(GRID_HEIGHT);
    localparam logic [MAG_W-1:0]  MAG_RESET  = MAG_W'(SITE_COUNT);
    localparam logic [BOND_W-1:0] BOND_RESET = BOND_W'(2 * SITE_COUNT);
    localparam logic [AW-1:0]     LAST_SITE  = AW'(SITE_COUNT - 1);

    // Flat site index, x * GRID_HEIGHT + y.
    function automatic logic [AW-1:0] f_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
        f_addr = AW'(AW'(x) * AW'(GRID_HEIGHT)) + AW'(y);
    endfunction

    t_state r_state, n_state;
    t_tap   r_tap;

    logic [AW-1:0]            r_clr;
    logic                     r_op;
    logic                     r_wbit;
    logic [RND_W-1:0]         r_rnd;
    logic [COORD_W-1:0]       r_x;
    logic [COORD_W-1:0]       r_y;
    logic                     r_old;
    logic signed [NSUM_W-1:0] r_nsum;
    logic [MAG_W-1:0]         r_mag;
    logic [BOND_W-1:0]        r_bond;
    logic [CFG_DATA_W-1:0]    r_thr_a;
    logic [CFG_DATA_W-1:0]    r_thr_b;
    logic [THR_C_W-1:0]       r_thr_c;
    logic                     r_out_valid;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic          ram_wdata;
    logic          ram_rdata;
    logic          load_out;

    // Decision held from the evaluation cycle for the result beat.
    logic ev_new_q, ev_change_q;

    // Coordinates reduced into the grid, and their wrapped neighbours.
    logic          x_big, y_big;
    logic [XW-1:0] xc, xp, xm;
    logic [YW-1:0] yc, yp, ym;
    logic [AW-1:0] addr_site, addr_tap;

    assign x_big = int'(r_x) >= GRID_WIDTH;
    assign y_big = int'(r_y) >= GRID_HEIGHT;
    assign xc    = XW'(r_x);
    assign yc    = YW'(r_y);
    assign xp    = (xc == XW'(GRID_WIDTH - 1)) ? '0 : xc + XW'(1);
    assign xm    = (xc == '0) ? XW'(GRID_WIDTH - 1) : xc - XW'(1);
    assign yp    = (yc == YW'(GRID_HEIGHT - 1)) ? '0 : yc + YW'(1);
    assign ym    = (yc == '0) ? YW'(GRID_HEIGHT - 1) : yc - YW'(1);
    assign addr_site = f_addr(xc, yc);

    always_comb begin
        case (r_tap)
            TAP_SITE: addr_tap = addr_site;
            TAP_XP:   addr_tap = f_addr(xp, yc);
            TAP_XM:   addr_tap = f_addr(xm, yc);
            TAP_YP:   addr_tap = f_addr(xc, yp);
            TAP_YM:   addr_tap = f_addr(xc, ym);
            default:  addr_tap = addr_site;
        endcase
    end

    // Acceptance decision and total deltas, used in the evaluation cycle.
    logic [THR_ALL_W-1:0]    thr_all;
    logic [3:0]              thr_k;
    logic [THR_W-1:0]        thr_sel;
    logic                    ev_new;
    logic                    ev_change;
    logic [MAG_W-1:0]        dm;
    logic [BOND_W-1:0]       db2;
    logic [BOND_W-1:0]       db;
    logic [NSUM_W-1:0]       nsum_off;

    assign thr_all  = {r_thr_c, r_thr_b, r_thr_a};
    assign nsum_off = NSUM_W'(r_nsum + 4'sd4);
    assign thr_k    = (r_old ? 4'd5 : 4'd0) + {1'b0, nsum_off[NSUM_W-1:1]};
    assign thr_sel  = thr_all[{thr_k, 4'b0000} +: THR_W];
    assign ev_new   = (r_op == OP_WRITE) ? r_wbit :
                      ((r_rnd <= thr_sel) ? ~r_old : r_old);
    assign ev_change = ev_new != r_old;
    assign dm       = ev_new ? MAG_W'(2) : -MAG_W'(2);
    assign db2      = BOND_W'(r_nsum) <<< 1;
    assign db       = ev_new ? db2 : -db2;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and memory port control.
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_addr  = addr_site;
        ram_wdata = 1'b1;
        o_ready   = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            S_CLR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
                if (r_clr == LAST_SITE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (!x_big && !y_big) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                ram_addr = addr_tap;
                if (r_tap == TAP_YM) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                ram_we    = ev_change;
                ram_wdata = ev_new;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Spin store, one bit per site.
    ismu_ram #(
        .WIDTH(1),
        .DEPTH(SITE_COUNT)
    ) u_spin_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Control registers, totals and thresholds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_tap       <= TAP_SITE;
            r_out_valid <= 1'b0;
            r_mag       <= MAG_RESET;
            r_bond      <= BOND_RESET;
            r_thr_a     <= '1;
            r_thr_b     <= '1;
            r_thr_c     <= '1;
        end else begin
            if (r_state == S_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == S_IDLE && i_valid) begin
                r_tap <= TAP_SITE;
            end else if (r_state == S_RD && r_tap != TAP_YM) begin
                r_tap <= t_tap'(r_tap + 3'd1);
            end
            if (r_state == S_EVAL && ev_change) begin
                r_mag  <= r_mag + dm;
                r_bond <= r_bond + db;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_THRESH_A: r_thr_a <= i_cfg_data;
                    CFG_THRESH_B: r_thr_b <= i_cfg_data;
                    CFG_THRESH_C: r_thr_c <= i_cfg_data[THR_C_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Item payload: captured on accept, reduced, then gathered from the memory reads.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_op   <= i_opcode;
                    r_wbit <= i_spin_value;
                    r_rnd  <= i_random_value;
                    r_x    <= i_site_x;
                    r_y    <= i_site_y;
                    r_nsum <= '0;
                end
            end
            S_RED: begin
                if (x_big) begin
                    r_x <= r_x - COORD_W'(GRID_WIDTH);
                end
                if (y_big) begin
                    r_y <= r_y - COORD_W'(GRID_HEIGHT);
                end
            end
            S_RD: begin
                // Read data is registered: it answers the address of the previous tap.
                if (r_tap == TAP_XP) begin
                    r_old <= ram_rdata;
                end else if (r_tap != TAP_SITE) begin
                    r_nsum <= r_nsum + (ram_rdata ? 4'sd1 : -4'sd1);
                end
            end
            S_LAST: begin
                r_nsum <= r_nsum + (ram_rdata ? 4'sd1 : -4'sd1);
            end
            default: ;
        endcase
    end

    // Result register: totals are already updated when the beat is loaded.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_flipped       <= ev_change_q;
            o_new_spin      <= ev_new_q;
            o_neighbour_sum <= r_nsum;
            o_magnetisation <= r_mag;
            o_bond_total    <= r_bond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL) begin
            ev_new_q    <= ev_new;
            ev_change_q <= ev_change;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

[sv/ismu_checker.sv]
// Port-level checker for the Ising Metropolis site update core, with its bind.
`default_nettype none

module ismu_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_valid,
    input wire logic                               o_ready,
    input wire logic                               o_valid,
    input wire logic                               i_ready,
    input wire logic                               o_flipped,
    input wire logic                               o_new_spin,
    input wire logic signed [ismu_pkg::NSUM_W-1:0] o_neighbour_sum,
    input wire logic signed [ismu_pkg::MAG_W-1:0]  o_magnetisation,
    input wire logic signed [ismu_pkg::BOND_W-1:0] o_bond_total
);

    import ismu_pkg::*;

    // The clearing pass keeps the input side closed in the first cycle after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !o_ready)
        else $error("input ready straight after reset");

    // One item at a time: an accepted beat closes the input side.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready in the cycle after an accepted beat");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_flipped) && $stable(o_new_spin)
            && $stable(o_neighbour_sum) && $stable(o_magnetisation) && $stable(o_bond_total))
        else $error("result beat changed while stalled");

    // Four neighbours of plus or minus one give an even sum within four.
    a_nsum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_neighbour_sum[0] && o_neighbour_sum >= -4 && o_neighbour_sum <= 4)
        else $error("neighbour sum out of range");

endmodule

bind ising_metropolis_site_update_core ismu_checker u_ismu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_flipped       (o_flipped),
    .o_new_spin      (o_new_spin),
    .o_neighbour_sum (o_neighbour_sum),
    .o_magnetisation (o_magnetisation),
    .o_bond_total    (o_bond_total)
);

`default_nettype wire
